// ===== rtl/ecpu_pkg.sv =====
// Shared types and constants for the escape-coded pixel bit unpacker.
`timescale 1ns / 1ps
`default_nettype none
package ecpu_pkg;

	localparam int WORD_W  = 32;
	localparam int BUF_W   = 64;
	localparam int HELD_W  = 7;
	localparam int PIX_W   = 25;
	localparam int CB_W    = 5;
	localparam int UB_W    = 5;
	localparam int OFS_W   = 17;
	localparam int CNT_W   = 25;
	localparam int FIELD_W = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 25;

	localparam logic [CB_W-1:0] MAX_CODE_BITS = 5'd16;
	localparam logic [UB_W-1:0] MAX_RAW_BITS  = 5'd24;

	localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNCOMPRESSED_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_OFFSET      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT       = 2'd3;

	localparam logic [CB_W-1:0]  RST_COMPRESSED_BITS   = 5'd6;
	localparam logic [UB_W-1:0]  RST_UNCOMPRESSED_BITS = 5'd14;
	localparam logic [OFS_W-1:0] RST_LEVEL_OFFSET      = '0;
	localparam logic [CNT_W-1:0] RST_PIXEL_COUNT       = 25'd1048576;

	typedef struct packed {
		logic signed [PIX_W-1:0] value;
		logic                    raw;
		logic                    frame_last;
		logic                    word_last;
	} pixel_t;

endpackage
`default_nettype wire

// ===== rtl/ecpu_field_unit.sv =====
// Shared field unit: extracts one field from the bit buffer and forms the pixel value.
`timescale 1ns / 1ps
`default_nettype none
module ecpu_field_unit
	import ecpu_pkg::*;
(
	input  wire logic [BUF_W-1:0]       bits_in,
	input  wire logic [CB_W-1:0]        width,
	input  wire logic                   code_mode,
	input  wire logic signed [OFS_W-1:0] offset,
	output logic [BUF_W-1:0]            rest,
	output logic                        field_zero,
	output logic signed [PIX_W-1:0]     value
);

	localparam logic [CB_W-1:0] FieldMax = 5'd24;

	logic [FIELD_W-1:0] mask;
	logic [FIELD_W-1:0] field;

	// Width is always between 1 and 24 here.
	assign mask       = {FIELD_W{1'b1}} >> (FieldMax - width);
	assign field      = bits_in[FIELD_W-1:0] & mask;
	assign rest       = bits_in >> width;
	assign field_zero = (field == '0);

	always_comb begin
		if (code_mode) begin
			value = $signed({{(PIX_W-OFS_W){offset[OFS_W-1]}}, offset})
				+ $signed({{(PIX_W-16){1'b0}}, field[15:0]});
		end else begin
			value = $signed({1'b0, field});
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ecpu_out_stage.sv =====
// Output register that holds one finished pixel until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none
module ecpu_out_stage
	import ecpu_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire pixel_t push_pix,
	output logic        free,
	input  wire logic   out_stall,
	output logic        out_valid,
	output pixel_t      out_pix
);

	logic   valid_q;
	pixel_t pix_q;

	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_pix   = pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pix_q <= push_pix;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/escape_coded_pixel_bit_unpacker.sv =====
// Top level of the escape-coded pixel bit unpacker: sequencer, state and configuration.
// Sequence: a word is accepted in the idle state, then code or raw fields are read one per cycle;
// the end of the word's bits is found and the last pixel is released from the flush state.
// Throughput: up to one pixel per cycle while a word is decoded and the output register has room;
// the single shared field unit reads one field at a time, and a new word is taken only when idle.
// Reset (arst_n, asynchronous, active low) empties the bit buffer, clears the pixel
// counter and the escape flag, and loads the documented register defaults.
`timescale 1ns / 1ps
`default_nettype none
module escape_coded_pixel_bit_unpacker
	import ecpu_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [WORD_W-1:0]      stream_word,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic signed [PIX_W-1:0]     pixel_value,
	output logic                        was_raw,
	output logic                        frame_last,
	output logic                        word_last,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DAT_W-1:0]   cfg_data
);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	// Configuration registers.
	logic [CB_W-1:0]         cb_q;
	logic [UB_W-1:0]         ub_q;
	logic signed [OFS_W-1:0] ofs_q;
	logic [CNT_W-1:0]        pc_q;

	// Decoder state.
	logic [1:0]        state_q;
	logic [BUF_W-1:0]  buf_q;
	logic [HELD_W-1:0] held_q;
	logic [CNT_W-1:0]  pd_q;
	logic              esc_q;
	logic [4:0]        nout_q;
	logic              pend_valid_q;
	pixel_t            pend_q;

	// Effective register values after clamping the out-of-range codes.
	logic [CB_W-1:0]  cb_eff;
	logic [UB_W-1:0]  ub_eff;
	logic [CNT_W-1:0] pc_eff;

	logic             code_mode;
	logic [CB_W-1:0]  need;
	logic             enough;
	logic [BUF_W-1:0] rest;
	logic             field_zero;
	logic signed [PIX_W-1:0] value;
	logic [CNT_W-1:0] pd_next;
	logic             frame_end;

	logic   out_free;
	logic   push;
	pixel_t push_pix;
	pixel_t out_pix;
	logic   blocked;
	logic   in_accept;

	assign cb_eff = (cb_q > MAX_CODE_BITS) ? MAX_CODE_BITS : cb_q;
	assign ub_eff = (ub_q > MAX_RAW_BITS) ? MAX_RAW_BITS
		: ((ub_q == '0) ? 5'd1 : ub_q);
	assign pc_eff = (pc_q == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : pc_q;

	// A code is read unless an escape is pending or every pixel is raw.
	assign code_mode = !esc_q && (cb_eff != '0);
	assign need      = code_mode ? cb_eff : ub_eff;
	assign enough    = held_q >= {{(HELD_W-CB_W){1'b0}}, need};

	ecpu_field_unit u_field (
		.bits_in    (buf_q),
		.width      (need),
		.code_mode  (code_mode),
		.offset     (ofs_q),
		.rest       (rest),
		.field_zero (field_zero),
		.value      (value)
	);

	// The frame closes when the count reaches the limit or wraps to zero.
	assign pd_next   = pd_q + {{(CNT_W-1){1'b0}}, 1'b1};
	assign frame_end = (pd_next >= pc_eff) || (pd_next == '0);

	// A step that would push the held pixel must wait for room in the output register.
	assign blocked   = pend_valid_q && !out_free;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// The held pixel moves to the output register once its successor exists
	// (not last of the word) or the word is finished (last of the word).
	always_comb begin
		push     = 1'b0;
		push_pix = pend_q;
		unique case (state_q)
			ST_RUN: begin
				if (!blocked && enough && pend_valid_q && !(code_mode && field_zero)) begin
					push               = 1'b1;
					push_pix.word_last = 1'b0;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					push               = 1'b1;
					push_pix.word_last = 1'b1;
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	ecpu_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_pix  (push_pix),
		.free      (out_free),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_pix   (out_pix)
	);

	assign pixel_value = out_pix.value;
	assign was_raw     = out_pix.raw;
	assign frame_last  = out_pix.frame_last;
	assign word_last   = out_pix.word_last;

	// Configuration writes; the index covers exactly the four registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cb_q  <= RST_COMPRESSED_BITS;
			ub_q  <= RST_UNCOMPRESSED_BITS;
			ofs_q <= RST_LEVEL_OFFSET;
			pc_q  <= RST_PIXEL_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COMPRESSED_BITS:   cb_q  <= cfg_data[CB_W-1:0];
				REG_UNCOMPRESSED_BITS: ub_q  <= cfg_data[UB_W-1:0];
				REG_LEVEL_OFFSET:      ofs_q <= cfg_data[OFS_W-1:0];
				REG_PIXEL_COUNT:       pc_q  <= cfg_data[CNT_W-1:0];
				default: begin
					cb_q <= cb_q;
				end
			endcase
		end
	end

	// Sequencer: one field per cycle through the shared field unit while the output register has room.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			buf_q        <= '0;
			held_q       <= '0;
			pd_q         <= '0;
			esc_q        <= 1'b0;
			nout_q       <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						// New bits land just above the bits still held.
						buf_q   <= buf_q | ({{(BUF_W-WORD_W){1'b0}}, stream_word} << held_q[4:0]);
						held_q  <= held_q + HELD_W'(WORD_W);
						nout_q  <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (!blocked) begin
						if (!enough) begin
							state_q <= pend_valid_q ? ST_FLUSH : ST_IDLE;
						end else begin
							buf_q  <= rest;
							held_q <= held_q - {{(HELD_W-CB_W){1'b0}}, need};
							if (code_mode && field_zero) begin
								esc_q <= 1'b1;
							end else begin
								esc_q        <= 1'b0;
								pend_valid_q <= 1'b1;
								nout_q       <= nout_q + 5'd1;
								if (frame_end) begin
									// Frame done: the rest of this word is dropped.
									buf_q   <= '0;
									held_q  <= '0;
									pd_q    <= '0;
									esc_q   <= 1'b0;
									state_q <= ST_FLUSH;
								end else begin
									pd_q <= pd_next;
									if (nout_q == 5'd31) begin
										state_q <= ST_FLUSH;
									end
								end
							end
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload of the pixel waiting to learn whether it ends the word.
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && !blocked && enough && !(code_mode && field_zero)) begin
			pend_q.value      <= value;
			pend_q.raw        <= !code_mode;
			pend_q.frame_last <= frame_end;
			pend_q.word_last  <= 1'b0;
		end
	end

	// Between words fewer than a full word of bits are ever carried over.
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (held_q < HELD_W'(WORD_W)))
		else $error("bit count carried between words is too large");

	// A pixel waiting for release never survives into the idle state.
	a_no_pending_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("pixel left behind at end of word");

	// After the final pixel of a frame all decoder state is clear.
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && pend_q.frame_last) |-> (pd_q == '0 && held_q == '0 && !esc_q))
		else $error("decoder state not cleared at frame end");

	// Every released last-of-word pixel is followed by a free input side.
	a_word_end: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_pix.word_last) |=> (state_q == ST_IDLE))
		else $error("word end released without returning to idle");

endmodule
`default_nettype wire
